// ===== rtl/core/glsw_pkg.sv =====
// Shared types, constants and helper functions for the grid line-of-sight walker.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package glsw_pkg;

    // Field widths.
    localparam int COORD_W  = 6;
    localparam int CODE_W   = 8;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Default grid side; the store holds GRID_SIDE by GRID_SIDE cells.
    localparam int GRID_SIDE_DEF = 64;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_LOAD          = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_IF_EMPTY = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY         = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'b1;

    // Both grid dimensions reset to the full 64 by 64 grid.
    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 7'd64;

    // Terrain codes that count as empty: '.', 'E' and 'w'.
    localparam logic [CODE_W-1:0] CODE_FLOOR = 8'h2E;
    localparam logic [CODE_W-1:0] CODE_EXIT  = 8'h45;
    localparam logic [CODE_W-1:0] CODE_WATER = 8'h77;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [CODE_W-1:0]  cell_code;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] path_x;
        logic [COORD_W-1:0] path_y;
        logic               blocked;
        logic               last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_query;
        logic write_now;
        logic read_cell;
        logic cond_write;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_done;
    } status_t;

    // True when a terrain code is walkable.
    function automatic logic code_is_empty(input logic [CODE_W-1:0] code);
        return (code == CODE_FLOOR) || (code == CODE_EXIT) || (code == CODE_WATER);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/glsw_ctrl.sv =====
// Controller state machine of the grid line-of-sight walker.
// Depends on glsw_pkg for the item, command and status types.
`default_nettype none

module glsw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [glsw_pkg::OP_W-1:0] opcode,
    output glsw_pkg::cmd_t         cmd,
    input  wire glsw_pkg::status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COND,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Decode the accepted item into one command and pick the next state.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (opcode)
                        glsw_pkg::OP_LOAD: begin
                            cmd.write_now = 1'b1;
                        end
                        glsw_pkg::OP_WRITE_IF_EMPTY: begin
                            cmd.read_cell = 1'b1;
                            state_next    = ST_COND;
                        end
                        glsw_pkg::OP_QUERY: begin
                            cmd.load_query = 1'b1;
                            state_next     = ST_WALK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COND: begin
                // The cell's code is back from the store; write if it is empty.
                cmd.cond_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_WALK: begin
                if (status.run_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // A conditional write returns to idle right after its decision state.
    a_cond_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COND) |=> (state_reg == ST_IDLE))
        else $error("conditional write did not return to idle");

    // A run only ends while a walk is in progress.
    a_done_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        status.run_done |-> (state_reg == ST_WALK))
        else $error("run finished outside a walk");

    // A query starts a walk on the next cycle.
    a_query_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_query |=> (state_reg == ST_WALK))
        else $error("query did not start a walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/glsw_datapath.sv =====
// Datapath of the grid line-of-sight walker: terrain store, line stepper,
// read stage and output register. Depends on glsw_pkg.
`default_nettype none

module glsw_datapath #(
    parameter int GRID_SIDE = glsw_pkg::GRID_SIDE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [glsw_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
    input  wire logic [glsw_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire glsw_pkg::in_item_t              s_item,
    input  wire glsw_pkg::cmd_t                  cmd,
    output glsw_pkg::status_t                    status,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output glsw_pkg::out_item_t                  m_item
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = glsw_pkg::COORD_W;
    localparam int EW    = CW + 3;
    localparam logic [8:0]    SIDE_CMP = 9'(GRID_SIDE);
    localparam logic [AW-1:0] SIDE_A   = AW'(GRID_SIDE);

    // Cell (x, y) lies inside the physical store.
    function automatic logic in_store(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return (9'(x) < SIDE_CMP) && (9'(y) < SIDE_CMP);
    endfunction

    // Store address of cell (x, y); zero for cells outside the store.
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
        logic [AW-1:0] a;
        a = AW'(y) * SIDE_A + AW'(x);
        return in_store(x, y) ? a : '0;
    endfunction

    // Configuration registers.
    logic [glsw_pkg::CFG_W-1:0] rows_reg;
    logic [glsw_pkg::CFG_W-1:0] cols_reg;

    // Cell (x, y) lies inside the grid in use.
    function automatic logic in_grid(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                     input logic [glsw_pkg::CFG_W-1:0] rows,
                                     input logic [glsw_pkg::CFG_W-1:0] cols);
        return in_store(x, y) && ({1'b0, x} < cols) && ({1'b0, y} < rows);
    endfunction

    // Terrain store, no reset.
    logic [glsw_pkg::CODE_W-1:0] mem [0:CELLS-1];
    logic [glsw_pkg::CODE_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [AW-1:0]               wr_addr;
    logic [glsw_pkg::CODE_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;

    // Pending conditional write.
    logic [AW-1:0]               w_addr_reg;
    logic [glsw_pkg::CODE_W-1:0] w_code_reg;
    logic                        w_ok_reg;

    // Line stepper.
    logic                  running_reg;
    logic [CW-1:0]         x_reg;
    logic [CW-1:0]         y_reg;
    logic signed [EW-1:0]  err_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  x_major_reg;
    logic                  sx_neg_reg;
    logic                  sy_neg_reg;
    logic [CW:0]           two_minor_reg;
    logic [CW:0]           two_major_reg;

    // Read stage: the point whose code is being fetched.
    logic          p_valid_reg;
    logic [CW-1:0] p_x_reg;
    logic [CW-1:0] p_y_reg;
    logic          p_last_reg;
    logic          p_in_grid_reg;

    // Output register.
    logic                m_valid_reg;
    glsw_pkg::out_item_t out_reg;

    // Query setup values from the accepted item.
    logic [CW-1:0] q_dx;
    logic [CW-1:0] q_dy;
    logic          q_x_major;
    logic [CW-1:0] q_major;
    logic [CW-1:0] q_minor;

    // Stepper and stage control.
    logic                 adv;
    logic                 iss;
    logic                 p_blocked;
    logic                 run_end;
    logic signed [EW-1:0] err_sub;
    logic                 minor_step;
    logic [CW-1:0]        x_inc;
    logic [CW-1:0]        y_inc;

    // Lengths and directions of a new line.
    always_comb begin
        q_dx = (s_item.dest_x >= s_item.point_x) ? (s_item.dest_x - s_item.point_x)
                                                 : (s_item.point_x - s_item.dest_x);
        q_dy = (s_item.dest_y >= s_item.point_y) ? (s_item.dest_y - s_item.point_y)
                                                 : (s_item.point_y - s_item.dest_y);
        q_x_major = (q_dx > q_dy);
        q_major   = q_x_major ? q_dx : q_dy;
        q_minor   = q_x_major ? q_dy : q_dx;
    end

    // One Bresenham step of the doubled error term.
    always_comb begin
        err_sub    = err_reg - EW'(two_minor_reg);
        minor_step = err_sub[EW-1];
        x_inc      = sx_neg_reg ? (x_reg - 1'b1) : (x_reg + 1'b1);
        y_inc      = sy_neg_reg ? (y_reg - 1'b1) : (y_reg + 1'b1);
    end

    // Handshake between stepper, read stage and output register.
    assign adv       = p_valid_reg && (!m_valid_reg || m_ready);
    assign p_blocked = !(p_in_grid_reg && glsw_pkg::code_is_empty(rd_data_reg));
    assign run_end   = adv && (p_last_reg || p_blocked);
    assign iss       = running_reg && (!p_valid_reg || adv);

    assign status.run_done = run_end;

    // Store port selection.
    always_comb begin
        rd_en   = iss || cmd.read_cell;
        rd_addr = iss ? cell_addr(x_reg, y_reg)
                      : cell_addr(s_item.point_x, s_item.point_y);
        if (cmd.cond_write) begin
            mem_we  = w_ok_reg && glsw_pkg::code_is_empty(rd_data_reg);
            wr_addr = w_addr_reg;
            wr_data = w_code_reg;
        end else begin
            mem_we  = cmd.write_now && in_store(s_item.point_x, s_item.point_y);
            wr_addr = cell_addr(s_item.point_x, s_item.point_y);
            wr_data = s_item.cell_code;
        end
    end

    // Terrain store with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers: configuration, stepper run flag, stage and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= glsw_pkg::CFG_RESET_VAL;
            cols_reg    <= glsw_pkg::CFG_RESET_VAL;
            running_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_idx == glsw_pkg::CFG_IDX_ROWS) begin
                    rows_reg <= cfg_wr_data;
                end else begin
                    cols_reg <= cfg_wr_data;
                end
            end

            if (cmd.load_query) begin
                running_reg <= 1'b1;
            end else if (run_end) begin
                running_reg <= 1'b0;
            end else if (iss && (cnt_reg == '0)) begin
                running_reg <= 1'b0;
            end

            // A point issued in the cycle that ends the run is dropped.
            if (run_end) begin
                p_valid_reg <= 1'b0;
            end else if (iss) begin
                p_valid_reg <= 1'b1;
            end else if (adv) begin
                p_valid_reg <= 1'b0;
            end

            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the stepper, stage, output and pending write.
    always_ff @(posedge aclk) begin
        if (cmd.read_cell) begin
            w_addr_reg <= cell_addr(s_item.point_x, s_item.point_y);
            w_code_reg <= s_item.cell_code;
            w_ok_reg   <= in_grid(s_item.point_x, s_item.point_y, rows_reg, cols_reg);
        end

        if (cmd.load_query) begin
            x_reg         <= s_item.point_x;
            y_reg         <= s_item.point_y;
            err_reg       <= EW'(q_major);
            cnt_reg       <= q_major;
            x_major_reg   <= q_x_major;
            sx_neg_reg    <= (s_item.point_x > s_item.dest_x);
            sy_neg_reg    <= (s_item.point_y > s_item.dest_y);
            two_minor_reg <= {q_minor, 1'b0};
            two_major_reg <= {q_major, 1'b0};
        end else if (iss) begin
            cnt_reg <= cnt_reg - 1'b1;
            err_reg <= minor_step ? (err_sub + EW'(two_major_reg)) : err_sub;
            if (x_major_reg) begin
                x_reg <= x_inc;
                if (minor_step) begin
                    y_reg <= y_inc;
                end
            end else begin
                y_reg <= y_inc;
                if (minor_step) begin
                    x_reg <= x_inc;
                end
            end
        end

        if (iss) begin
            p_x_reg       <= x_reg;
            p_y_reg       <= y_reg;
            p_last_reg    <= (cnt_reg == '0);
            p_in_grid_reg <= in_grid(x_reg, y_reg, rows_reg, cols_reg);
        end

        if (adv) begin
            out_reg.path_x  <= p_x_reg;
            out_reg.path_y  <= p_y_reg;
            out_reg.blocked <= p_blocked;
            out_reg.last    <= p_last_reg || p_blocked;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

`ifndef SYNTHESIS
    // Once the final point of a line is issued, the stepper has stopped.
    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && p_last_reg) |-> !running_reg)
        else $error("stepper still running after the final point");

    // A new query never lands on a walk in progress.
    a_query_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_query |-> (!running_reg && !p_valid_reg))
        else $error("query started during a walk");

    // After a run ends, nothing of it is left in the stepper or the read stage.
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        run_end |=> (!running_reg && !p_valid_reg))
        else $error("points left in flight after the run ended");

    // Writes and walk reads never share a cycle.
    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && iss))
        else $error("store write during a walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/grid_line_of_sight_walker_unit.sv =====
// Grid line-of-sight walker: a GRID_SIDE by GRID_SIDE terrain store with
// a Bresenham line walker that checks each cell it passes.
// Use:
//   The input channel (s_valid, s_ready, s_item) takes one item per
//   handshake. Opcode 0 loads a cell, opcode 1 writes a cell only if it is
//   empty, opcode 2 walks a line from (point_x, point_y) to (dest_x, dest_y).
//   Opcode 3 is taken and ignored.
//   The result channel (m_valid, m_ready, m_item) gives one item per line
//   point, in order. The first non-empty or off-grid point is flagged
//   blocked and ends the run; last marks the final item of every run.
// Timing:
//   A load writes the store as it is accepted; a conditional write reads the
//   cell, then decides in ST_COND. A query's points pass the stepper, the read
//   stage and the output register, one point per cycle while m_ready is high;
//   the pace is set by the single read port of the store, one cell per cycle.
//   The next item is taken once the last point has reached the output
//   register, even if that point is still waiting to be taken.
// Reset and stall:
//   Reset clears the controller, the walk and the output register and sets
//   both grid dimensions to 64; the store is not cleared. While m_ready is
//   low the walk pauses with no point lost. Configuration writes
//   (cfg_wr_en, cfg_wr_idx, cfg_wr_data) belong in idle periods.
`default_nettype none

module grid_line_of_sight_walker_unit #(
    parameter int GRID_SIDE = glsw_pkg::GRID_SIDE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [glsw_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
    input  wire logic [glsw_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire glsw_pkg::in_item_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output glsw_pkg::out_item_t                  m_item
);

    glsw_pkg::cmd_t    cmd;
    glsw_pkg::status_t status;

    // Sequencing of loads, conditional writes and walks.
    glsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_item.opcode),
        .cmd     (cmd),
        .status  (status)
    );

    // Store, line stepper and output register.
    glsw_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the grid line-of-sight walker: a directed table followed by random
// loads, conditional writes and line queries over several grid sizes, all scored by
// an in-bench predictor. Depends on glsw_pkg and grid_line_of_sight_walker_unit.
`timescale 1ns / 100ps

module tb;
    import glsw_pkg::*;

    localparam int SIDE          = GRID_SIDE_DEF;
    localparam int RANDOM_ITEMS  = 210;
    localparam int PHASE_LEN     = 35;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int DIR_ROWS      = 24;

    // Opcode 3 is accepted and dropped by the block.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    // A terrain code that always blocks the line.
    localparam logic [CODE_W-1:0] CODE_WALL = 8'h23;

    typedef enum logic {ROW_ITEM, ROW_GRID} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        in_item_t         item;
        logic             typed;
        out_item_t        want;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } stim_row_t;

    // Directed table. Rows with typed set carry their single line point; all other
    // rows are scored by the predictor. GRID rows resize the grid in use.
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM, '{OP_LOAD, 6'd0, 6'd0, CODE_FLOOR, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, 1'b1}, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_LOAD, 6'd63, 6'd63, CODE_EXIT, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd63, 6'd63, 8'd0, 6'd63, 6'd63}, 1'b1,
          '{6'd63, 6'd63, 1'b0, 1'b1}, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_LOAD, 6'd1, 6'd0, CODE_WALL, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_LOAD, 6'd2, 6'd0, CODE_WATER, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd2, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_WRITE_IF_EMPTY, 6'd1, 6'd0, CODE_FLOOR, 6'd0, 6'd0}, 1'b0, '0,
          7'd0, 7'd0},
        '{ROW_ITEM, '{OP_WRITE_IF_EMPTY, 6'd2, 6'd0, 8'hFF, 6'd0, 6'd0}, 1'b0, '0,
          7'd0, 7'd0},
        '{ROW_ITEM, '{OP_LOAD, 6'd1, 6'd0, CODE_EXIT, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd2, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd63, 6'd63}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd63, 6'd63, 8'd0, 6'd0, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd63, 8'd0, 6'd63, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd63, 6'd0, 8'd0, 6'd0, 6'd5}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd5, 6'd0, 8'd0, 6'd7, 6'd63}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_IGNORED, 6'd63, 6'd63, 8'd255, 6'd63, 6'd63}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_GRID, '0, 1'b0, '0, 7'd1, 7'd1},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, 1'b1}, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd1, 6'd0, 8'd0, 6'd1, 6'd0}, 1'b1,
          '{6'd1, 6'd0, 1'b1, 1'b1}, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd3, 6'd0}, 1'b0, '0, 7'd0, 7'd0},
        '{ROW_ITEM, '{OP_WRITE_IF_EMPTY, 6'd1, 6'd0, CODE_FLOOR, 6'd0, 6'd0}, 1'b0, '0,
          7'd0, 7'd0},
        '{ROW_GRID, '0, 1'b0, '0, 7'd64, 7'd64},
        '{ROW_ITEM, '{OP_QUERY, 6'd0, 6'd0, 8'd0, 6'd2, 6'd0}, 1'b0, '0, 7'd0, 7'd0}
    };

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_idx  = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_item_t             s_item      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b1;
    out_item_t            m_item;

    // Predictor state: terrain copy, which cells have been loaded, grid in use.
    logic [CODE_W-1:0] terrain    [SIDE*SIDE];
    bit                cell_known [SIDE*SIDE];
    logic [CFG_W-1:0]  grid_rows_cfg = CFG_RESET_VAL;
    logic [CFG_W-1:0]  grid_cols_cfg = CFG_RESET_VAL;

    out_item_t pending_points [$];
    out_item_t walk_pts [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req    = 1'b0;
    bit  rough_fill  = 1'b0;
    int  errors      = 0;
    int  cycle_count = 0;
    int  n_loads     = 0;
    int  n_cond      = 0;
    int  n_queries   = 0;
    int  n_blocked   = 0;
    int  n_points    = 0;

    grid_line_of_sight_walker_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Floor, exit and water are the only walkable codes.
    function automatic bit is_walkable(logic [CODE_W-1:0] code);
        return code == CODE_FLOOR || code == CODE_EXIT || code == CODE_WATER;
    endfunction

    // A cell is open when it is inside the grid in use and holds a walkable code.
    function automatic bit cell_open(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        if (x >= grid_cols_cfg || y >= grid_rows_cfg)
            return 1'b0;
        return is_walkable(terrain[y*SIDE + x]);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code(int pct_walkable);
        if (int'($urandom_range(99)) < pct_walkable) begin
            case ($urandom_range(2))
                0: return CODE_FLOOR;
                1: return CODE_EXIT;
                default: return CODE_WATER;
            endcase
        end
        return CODE_W'($urandom_range(255));
    endfunction

    // Bresenham walk with a doubled error term; fills walk_pts with every point
    // from source to destination, ignoring terrain.
    function automatic void trace_line(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                       logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
        int dx, dy, sx, sy, x, y, err, major;
        out_item_t pt;
        walk_pts.delete();
        dx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        dy = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
        sx = (x0 > x1) ? -1 : 1;
        sy = (y0 > y1) ? -1 : 1;
        x = x0;
        y = y0;
        major = (dx > dy) ? dx : dy;
        err = major;
        for (int i = 0; i <= major; i++) begin
            pt = '0;
            pt.path_x = COORD_W'(x);
            pt.path_y = COORD_W'(y);
            walk_pts.push_back(pt);
            if (dx > dy) begin
                err -= 2 * dy;
                if (err < 0) begin
                    y += sy;
                    err += 2 * dx;
                end
                x += sx;
            end else begin
                err -= 2 * dx;
                if (err < 0) begin
                    x += sx;
                    err += 2 * dy;
                end
                y += sy;
            end
        end
    endfunction

    // Update the terrain copy for one accepted item and queue the line points it causes.
    function automatic void apply_item(in_item_t it, logic typed, out_item_t want);
        int idx;
        out_item_t pt;
        idx = it.point_y * SIDE + it.point_x;
        case (it.opcode)
            OP_LOAD: begin
                terrain[idx] = it.cell_code;
                cell_known[idx] = 1'b1;
                n_loads++;
            end
            OP_WRITE_IF_EMPTY: begin
                n_cond++;
                if (cell_open(it.point_x, it.point_y))
                    terrain[idx] = it.cell_code;
            end
            OP_QUERY: begin
                n_queries++;
                trace_line(it.point_x, it.point_y, it.dest_x, it.dest_y);
                foreach (walk_pts[k]) begin
                    pt = walk_pts[k];
                    pt.blocked = !cell_open(pt.path_x, pt.path_y);
                    pt.last = pt.blocked || (k == walk_pts.size() - 1);
                    if (!typed)
                        pending_points.push_back(pt);
                    if (pt.blocked) begin
                        n_blocked++;
                        break;
                    end
                end
                if (typed)
                    pending_points.push_back(want);
            end
            default: ;
        endcase
    endfunction

    // Compare one line point against the oldest expectation.
    function automatic void check_point(out_item_t got);
        out_item_t exp_pt;
        n_points++;
        if (pending_points.size() == 0) begin
            $error("unexpected line point x=%0d y=%0d", got.path_x, got.path_y);
            errors++;
            return;
        end
        exp_pt = pending_points.pop_front();
        if (got.path_x !== exp_pt.path_x) begin
            $error("path_x: expected %0d, got %0d", exp_pt.path_x, got.path_x);
            errors++;
        end
        if (got.path_y !== exp_pt.path_y) begin
            $error("path_y: expected %0d, got %0d", exp_pt.path_y, got.path_y);
            errors++;
        end
        if (got.blocked !== exp_pt.blocked) begin
            $error("blocked: expected %0b, got %0b", exp_pt.blocked, got.blocked);
            errors++;
        end
        if (got.last !== exp_pt.last) begin
            $error("last: expected %0b, got %0b", exp_pt.last, got.last);
            errors++;
        end
    endfunction

    // Offer one item, with a random gap first, and wait for it to be taken.
    task automatic send_item(in_item_t it);
        if (int'($urandom_range(99)) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (int'($urandom_range(99)) < tx_idle_pct);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Load every never-written cell that an item would read, so that no read of an
    // undefined cell inside the grid in use can happen.
    task automatic pave_cells(in_item_t it);
        out_item_t pts [$];
        out_item_t pt;
        in_item_t  ld;
        logic [63:0] noise;
        int idx;
        if (it.opcode == OP_WRITE_IF_EMPTY) begin
            pt = '0;
            pt.path_x = it.point_x;
            pt.path_y = it.point_y;
            pts.push_back(pt);
        end else begin
            trace_line(it.point_x, it.point_y, it.dest_x, it.dest_y);
            pts = walk_pts;
        end
        foreach (pts[k]) begin
            if (pts[k].path_x >= grid_cols_cfg || pts[k].path_y >= grid_rows_cfg)
                break;
            idx = pts[k].path_y * SIDE + pts[k].path_x;
            if (!cell_known[idx]) begin
                noise = {$urandom(), $urandom()};
                ld = noise[$bits(in_item_t)-1:0];
                ld.opcode    = OP_LOAD;
                ld.point_x   = pts[k].path_x;
                ld.point_y   = pts[k].path_y;
                ld.cell_code = rough_fill ? pick_code(92) : CODE_FLOOR;
                send_item(ld);
                apply_item(ld, 1'b0, '0);
            end
            if (!is_walkable(terrain[idx]))
                break;
        end
    endtask

    task automatic issue(in_item_t it, logic typed, out_item_t want);
        if (it.opcode == OP_QUERY || it.opcode == OP_WRITE_IF_EMPTY)
            pave_cells(it);
        send_item(it);
        apply_item(it, typed, want);
    endtask

    // Resize the grid once every line point is out and the block has settled.
    task automatic program_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= CFG_IDX_ROWS;
        cfg_wr_data <= rows;
        @(posedge aclk);
        cfg_wr_idx  <= CFG_IDX_COLS;
        cfg_wr_data <= cols;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grid_rows_cfg = rows;
        grid_cols_cfg = cols;
    endtask

    // Result side: score each taken point, stall at random, and honor a long hold.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_point(m_item);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed table, then random phases over several grid sizes.
    initial begin
        stim_row_t   row;
        in_item_t    it;
        logic [63:0] noise;
        int counted, cur_phase, r, lim_x, lim_y, tx, ty;
        bit hold_done;
        counted   = 0;
        cur_phase = -1;
        hold_done = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 19;
        rx_idle_pct = 82;
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_GRID)
                program_grid(row.rows, row.cols);
            else
                issue(row.item, row.typed, row.want);
        end

        rough_fill = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            // Grid size per phase: full, one row, one column, oversized, random, full.
            if (counted / PHASE_LEN != cur_phase) begin
                cur_phase = counted / PHASE_LEN;
                case (cur_phase)
                    0: program_grid(7'd64, 7'd64);
                    1: program_grid(7'd1, 7'd64);
                    2: program_grid(7'd64, 7'd1);
                    3: program_grid(7'd127, 7'd40);
                    4: program_grid(CFG_W'($urandom_range(63, 2)),
                                    CFG_W'($urandom_range(63, 2)));
                    default: program_grid(7'd64, 7'd64);
                endcase
            end

            // Idle pattern: slow receiver, then slow sender, then full rate with one hold.
            if (counted < 70) begin
                tx_idle_pct = 19;
                rx_idle_pct = 82;
            end else if (counted < 140) begin
                tx_idle_pct = 82;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                if (!hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
            end

            lim_x = (grid_cols_cfg > SIDE) ? SIDE : grid_cols_cfg;
            lim_y = (grid_rows_cfg > SIDE) ? SIDE : grid_rows_cfg;
            noise = {$urandom(), $urandom()};
            it = noise[$bits(in_item_t)-1:0];
            r = $urandom_range(99);
            if (r < 50) begin
                // Line query: source mostly inside the grid, destination mostly nearby.
                it.opcode = OP_QUERY;
                if ($urandom_range(99) < 85) begin
                    it.point_x = COORD_W'($urandom_range(lim_x - 1, 0));
                    it.point_y = COORD_W'($urandom_range(lim_y - 1, 0));
                end
                r = $urandom_range(99);
                if (r < 65) begin
                    tx = int'(it.point_x) + int'($urandom_range(12)) - 6;
                    ty = int'(it.point_y) + int'($urandom_range(12)) - 6;
                    it.dest_x = COORD_W'((tx < 0) ? 0 : (tx > SIDE - 1) ? SIDE - 1 : tx);
                    it.dest_y = COORD_W'((ty < 0) ? 0 : (ty > SIDE - 1) ? SIDE - 1 : ty);
                end else if (r >= 85) begin
                    it.dest_x = $urandom_range(1) ? 6'd63 : 6'd0;
                    it.dest_y = $urandom_range(1) ? 6'd63 : 6'd0;
                end
            end else if (r < 68) begin
                it.opcode = OP_WRITE_IF_EMPTY;
                if ($urandom_range(99) < 60) begin
                    it.point_x = COORD_W'($urandom_range(lim_x - 1, 0));
                    it.point_y = COORD_W'($urandom_range(lim_y - 1, 0));
                end
                it.cell_code = pick_code(50);
            end else if (r < 93) begin
                it.opcode = OP_LOAD;
                if ($urandom_range(99) < 70) begin
                    it.point_x = COORD_W'($urandom_range(lim_x - 1, 0));
                    it.point_y = COORD_W'($urandom_range(lim_y - 1, 0));
                end
                it.cell_code = pick_code(75);
            end else begin
                it.opcode = OP_IGNORED;
            end
            if (it.opcode != OP_IGNORED)
                counted++;
            issue(it, 1'b0, '0);
        end

        // Drain the remaining line points, then let the block settle.
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d queries with %0d line points checked (%0d runs blocked),",
                 n_queries, n_points, n_blocked);
        $display("%0d cell loads and %0d conditional writes across six grid sizes.",
                 n_loads, n_cond);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
